// ===== src/ipmdp_pkg.sv =====
// shared types, constants and palette entry function for the mono dither packer
package ipmdp_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int TBL_AW        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // operation codes
    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_PIXEL   = 1'b1;

    // table entry layout: [1:0] top pattern, [3:2] bottom pattern, [4] ink
    localparam int          ENTRY_W     = 5;
    localparam int          INK_POS     = 4;
    localparam logic [4:0]  ENTRY_RESET = 5'h00;
    localparam logic [4:0]  ENTRY0_RESET = 5'h10;

    // luminance thresholds
    localparam logic [7:0] INK_LIMIT = 8'd112;
    localparam logic [7:0] LVL_STEP1 = 8'd26;
    localparam logic [7:0] LVL_STEP2 = 8'd77;
    localparam logic [7:0] LVL_STEP3 = 8'd128;
    localparam logic [7:0] LVL_STEP4 = 8'd179;

    // last phase of a byte in each mode
    localparam logic [2:0] DITHER_LAST = 3'd3;
    localparam logic [2:0] MONO_LAST   = 3'd7;

    typedef struct packed {
        logic       operation;
        logic [7:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } item_word_t;

    typedef struct packed {
        logic [7:0] top_byte;
        logic [7:0] bottom_byte;
    } result_word_t;

    function automatic logic [1:0] lvl_top(input logic [2:0] lvl);
        logic [1:0] p;
        case (lvl)
            3'd0:    p = 2'h0;
            3'd1:    p = 2'h0;
            3'd2:    p = 2'h2;
            3'd3:    p = 2'h2;
            default: p = 2'h3;
        endcase
        return p;
    endfunction

    function automatic logic [1:0] lvl_bot(input logic [2:0] lvl);
        logic [1:0] p;
        case (lvl)
            3'd0:    p = 2'h0;
            3'd1:    p = 2'h2;
            3'd2:    p = 2'h2;
            3'd3:    p = 2'h3;
            default: p = 2'h3;
        endcase
        return p;
    endfunction

    // (lum + 25) / 51 clipped to 4 is the count of thresholds reached
    function automatic logic [4:0] make_entry(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
        logic [10:0] sum;
        logic [7:0]  lum;
        logic [2:0]  lvl;
        logic        ink;
        sum = {2'b00, r, 1'b0} + {1'b0, g, 2'b00} + {3'b000, g} + {3'b000, b};
        lum = sum[10:3];
        lvl = 3'(lum >= LVL_STEP1) + 3'(lum >= LVL_STEP2)
            + 3'(lum >= LVL_STEP3) + 3'(lum >= LVL_STEP4);
        ink = (lum < INK_LIMIT);
        return {ink, lvl_bot(lvl), lvl_top(lvl)};
    endfunction

endpackage

// ===== src/indexed_pixel_mono_dither_packer.sv =====
// top level: palette table memory, pixel packing stage and output register
// a pixel that completes a byte reaches result through the table read register and then
//   the output register; it waits in the pack stage while the output register is full and not taken
// throughput: one word per cycle, palette writes and pixels alike; the single
//   table read port plus the output register set this, stalls only on result back-pressure
// reset: control, accumulators and mode clear at once; the table reads as zero but for
//   entry 0, which has ink set, through per-entry valid bits, so no clearing pass
module indexed_pixel_mono_dither_packer
    import ipmdp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  item_word_t   item,
    output logic         result_valid,
    input  logic         result_ready,
    output result_word_t result,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data
);

    // palette memory, no reset; valid bits tell written entries apart
    logic [ENTRY_W-1:0]       mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] wr_seen_reg;

    // pack stage registers
    logic               pix_valid_reg;
    logic [ENTRY_W-1:0] rdata_reg;
    logic               rd_seen_reg;
    logic               rd_zero_reg;
    logic               rd_in_range_reg;

    logic       mono_mode_reg;
    logic [7:0] top_acc_reg, top_acc_next;
    logic [7:0] bot_acc_reg, bot_acc_next;
    logic [2:0] phase_reg,   phase_next;

    logic         out_valid_reg;
    result_word_t out_data_reg;

    logic              accept;
    logic              in_range;
    logic [TBL_AW-1:0] addr;
    logic              wr_en;
    logic              rd_en;
    logic [ENTRY_W-1:0] entry;
    logic              at_last;
    logic              stall;
    logic              advance;
    logic              emit;
    result_word_t      emit_word;

    assign in_range = ({1'b0, item.index} < 9'(TABLE_ENTRIES));
    assign addr     = item.index[TBL_AW-1:0];
    assign accept   = item_valid && item_ready;
    assign wr_en    = accept && (item.operation == OP_PALETTE) && in_range;
    assign rd_en    = accept && (item.operation == OP_PIXEL);

    // a pixel that closes a byte waits while the output register is still full
    assign at_last    = mono_mode_reg ? (phase_reg >= MONO_LAST) : (phase_reg >= DITHER_LAST);
    assign stall      = pix_valid_reg && at_last && out_valid_reg && !result_ready;
    assign advance    = pix_valid_reg && !stall;
    assign emit       = advance && at_last;
    assign item_ready = !stall;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= make_entry(item.red, item.green, item.blue);
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_seen_reg <= '0;
        end
        else if (wr_en)
        begin
            wr_seen_reg[addr] <= 1'b1;
        end
    end

    // side info captured with the read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_seen_reg     <= wr_seen_reg[addr];
            rd_zero_reg     <= (item.index == 8'd0);
            rd_in_range_reg <= in_range;
        end
    end

    // entry as the table holds it; out-of-range reads give an empty entry
    always_comb
    begin
        if (!rd_in_range_reg)
        begin
            entry = ENTRY_RESET;
        end
        else if (rd_seen_reg)
        begin
            entry = rdata_reg;
        end
        else if (rd_zero_reg)
        begin
            entry = ENTRY0_RESET;
        end
        else
        begin
            entry = ENTRY_RESET;
        end
    end

    // shift the pixel's bits into the accumulators
    always_comb
    begin
        if (mono_mode_reg)
        begin
            top_acc_next = {top_acc_reg[6:0], ~entry[INK_POS]};
            bot_acc_next = 8'd0;
        end
        else
        begin
            top_acc_next = {top_acc_reg[5:0], entry[1:0]};
            bot_acc_next = {bot_acc_reg[5:0], entry[3:2]};
        end
        phase_next            = phase_reg + 3'd1;
        emit_word.top_byte    = top_acc_next;
        emit_word.bottom_byte = bot_acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            mono_mode_reg <= 1'b0;
            top_acc_reg   <= '0;
            bot_acc_reg   <= '0;
            phase_reg     <= '0;
        end
        else
        begin
            pix_valid_reg <= rd_en || stall;
            if (cfg_wr_en)
            begin
                // mode change drops any partial byte
                mono_mode_reg <= cfg_wr_data;
                top_acc_reg   <= '0;
                bot_acc_reg   <= '0;
                phase_reg     <= '0;
            end
            else if (emit)
            begin
                top_acc_reg <= '0;
                bot_acc_reg <= '0;
                phase_reg   <= '0;
            end
            else if (advance)
            begin
                top_acc_reg <= top_acc_next;
                bot_acc_reg <= bot_acc_next;
                phase_reg   <= phase_next;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= emit_word;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

// ===== bench/tb_indexed_pixel_mono_dither_packer.sv =====
// testbench for the indexed pixel mono dither packer: directed and random words, self-checking
`timescale 1ns / 1ps

module tb_indexed_pixel_mono_dither_packer;
    import ipmdp_pkg::*;

    // mode register values
    localparam logic MODE_DITHER = 1'b0;
    localparam logic MODE_MONO   = 1'b1;

    // luminance to level mapping: level = (lum + 25) / 51, capped at the top level
    localparam int unsigned LEVEL_ROUND   = 25;
    localparam int unsigned LEVEL_STEP    = 51;
    localparam int unsigned LEVEL_TOP     = 4;
    localparam int unsigned INK_THRESHOLD = 112;

    // 2x2 bayer patterns per level, level 0 in the low bits
    localparam logic [9:0] TOP_PATTERNS    = {2'h3, 2'h2, 2'h2, 2'h0, 2'h0};
    localparam logic [9:0] BOTTOM_PATTERNS = {2'h3, 2'h3, 2'h2, 2'h2, 2'h0};

    // the block answers through its table read and output registers once a byte completes, so
    // a quiet settle after the last word is enough before a mode write or the end of the run
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 80;
    localparam int TIMEOUT_NS    = 2000000;
    localparam int REPORT_LIMIT  = 10;

    logic         clk;
    logic         rst_n;
    logic         item_valid;
    logic         item_ready;
    item_word_t   item;
    logic         result_valid;
    logic         result_ready;
    result_word_t result;
    logic         cfg_wr_en;
    logic         cfg_wr_data;

    indexed_pixel_mono_dither_packer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // packer model: palette copy, accumulators, phase and mode
    // entry layout: [1:0] top pattern, [3:2] bottom pattern, [4] ink
    // ------------------------------------------------------------------
    logic [4:0]   palette_model [TABLE_ENTRIES];
    logic [7:0]   top_acc;
    logic [7:0]   bottom_acc;
    logic [2:0]   pack_phase;
    logic         mono_model;
    result_word_t expected_bytes [$];

    // knobs shared between the sender, the result sink and the tests
    int send_gap_max = 6;
    int recv_gap_max = 6;
    int ready_hold_request = 0;

    // run statistics
    int mismatches    = 0;
    int words_checked = 0;
    int palette_writes = 0;
    int pixels_sent   = 0;
    int mode_writes   = 0;

    function automatic logic [4:0] palette_entry(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b);
        int unsigned lum;
        int unsigned level;
        lum   = (2 * r + 5 * g + b) >> 3;
        level = (lum + LEVEL_ROUND) / LEVEL_STEP;
        if (level > LEVEL_TOP)
            level = LEVEL_TOP;
        return {lum < INK_THRESHOLD, BOTTOM_PATTERNS[2 * level +: 2],
                TOP_PATTERNS[2 * level +: 2]};
    endfunction

    // update the model with one accepted word, queue a packed byte pair when one completes
    function automatic void advance_packer(input item_word_t w);
        logic [4:0]   entry;
        result_word_t done;
        entry = 5'h00;
        if (w.operation == OP_PALETTE)
        begin
            // palette writes never touch the accumulators
            if (w.index < TABLE_ENTRIES)
                palette_model[w.index] = palette_entry(w.red, w.green, w.blue);
            palette_writes++;
        end
        else
        begin
            pixels_sent++;
            if (w.index < TABLE_ENTRIES)
                entry = palette_model[w.index];
            if (mono_model == MODE_MONO)
            begin
                // paper is the inverse of ink, shifted in msb first
                top_acc    = {top_acc[6:0], ~entry[4]};
                bottom_acc = 8'h00;
                if (pack_phase >= 3'd7)
                begin
                    done.top_byte    = top_acc;
                    done.bottom_byte = 8'h00;
                    expected_bytes.push_back(done);
                    top_acc    = 8'h00;
                    pack_phase = 3'd0;
                end
                else
                begin
                    pack_phase = pack_phase + 3'd1;
                end
            end
            else
            begin
                top_acc    = {top_acc[5:0], entry[1:0]};
                bottom_acc = {bottom_acc[5:0], entry[3:2]};
                if (pack_phase >= 3'd3)
                begin
                    done.top_byte    = top_acc;
                    done.bottom_byte = bottom_acc;
                    expected_bytes.push_back(done);
                    top_acc    = 8'h00;
                    bottom_acc = 8'h00;
                    pack_phase = 3'd0;
                end
                else
                begin
                    pack_phase = pack_phase + 3'd1;
                end
            end
        end
    endfunction

    function automatic void flag_error(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------
    // word builders
    // ------------------------------------------------------------------
    function automatic item_word_t pixel_word(input logic [7:0] idx);
        item_word_t w;
        w.operation = OP_PIXEL;
        w.index     = idx;
        w.red       = 8'($urandom);
        w.green     = 8'($urandom);
        w.blue      = 8'($urandom);
        return w;
    endfunction

    // gray writes put the luminance exactly at the given value
    function automatic item_word_t gray_word(input logic [7:0] idx, input logic [7:0] lum);
        item_word_t w;
        w.operation = OP_PALETTE;
        w.index     = idx;
        w.red       = lum;
        w.green     = lum;
        w.blue      = lum;
        return w;
    endfunction

    // components lean toward the rails now and then
    function automatic logic [7:0] random_component();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    // one palette write in four; half the indexes fall in a small hot set so
    // pixels mostly land on entries that were written
    function automatic item_word_t random_word();
        item_word_t w;
        w.operation = ($urandom_range(0, 3) == 0) ? OP_PALETTE : OP_PIXEL;
        w.index     = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        w.red       = random_component();
        w.green     = random_component();
        w.blue      = random_component();
        return w;
    endfunction

    // ------------------------------------------------------------------
    // clock and run limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // result sink: ready drops for a random count after each word, or for a
    // long stretch when a test asks for one
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int stall_left;
        result_ready = 1'b0;
        stall_left   = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
                stall_left = $urandom_range(0, recv_gap_max);
            if (ready_hold_request > 0)
            begin
                stall_left         = ready_hold_request;
                ready_hold_request = 0;
            end
            if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // checker: every word taken off the output matches the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : byte_checker
        result_word_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                flag_error($sformatf("unexpected word top=%02h bottom=%02h",
                                     result.top_byte, result.bottom_byte));
            end
            else
            begin
                want = expected_bytes.pop_front();
                words_checked++;
                if (result.top_byte !== want.top_byte)
                    flag_error($sformatf("top byte expected %02h got %02h",
                                         want.top_byte, result.top_byte));
                if (result.bottom_byte !== want.bottom_byte)
                    flag_error($sformatf("bottom byte expected %02h got %02h",
                                         want.bottom_byte, result.bottom_byte));
            end
        end
    end

    // ------------------------------------------------------------------
    // shared sender and phase helpers
    // ------------------------------------------------------------------

    // offer one word after a random gap; valid stays up across back-to-back words
    task automatic send_word(input item_word_t w);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        advance_packer(w);
    endtask

    // stop offering, let every predicted word come out, then let the pipe settle
    task automatic wait_for_bytes();
        int waited;
        waited = 0;
        item_valid <= 1'b0;
        while (expected_bytes.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mode write only with the block idle; it also drops any partial byte
    task automatic set_mode(input logic mode);
        wait_for_bytes();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mono_model = mode;
        top_acc    = 8'h00;
        bottom_acc = 8'h00;
        pack_phase = 3'd0;
        mode_writes++;
    endtask

    task automatic run_random_phase(input logic mode, input int count, input int tx_gap,
                                    input int rx_gap);
        set_mode(mode);
        send_gap_max = tx_gap;
        recv_gap_max = rx_gap;
        repeat (count) send_word(random_word());
        wait_for_bytes();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // fresh table: entry 0 carries ink, every other entry reads as blank paper
    task automatic test_unwritten_entries();
        send_word(pixel_word(8'd0));
        send_word(pixel_word(8'd255));
        send_word(pixel_word(8'd1));
        send_word(pixel_word(8'd128));
        set_mode(MODE_MONO);
        send_word(pixel_word(8'd0));
        send_word(pixel_word(8'd255));
        send_word(pixel_word(8'd0));
        send_word(pixel_word(8'd1));
        send_word(pixel_word(8'd2));
        send_word(pixel_word(8'd3));
        send_word(pixel_word(8'd0));
        send_word(pixel_word(8'd200));
        wait_for_bytes();
    endtask

    // level and ink boundaries, the rails, and a palette write in the middle of a byte
    task automatic test_palette_levels();
        set_mode(MODE_DITHER);
        send_word(gray_word(8'd1, 8'd25));     // last luminance of level 0
        send_word(gray_word(8'd2, 8'd26));     // first of level 1
        send_word(gray_word(8'd3, 8'd111));    // still ink
        send_word(gray_word(8'd4, 8'd112));    // first paper
        send_word(gray_word(8'd0, 8'd0));      // black
        send_word(gray_word(8'd255, 8'd255));  // white, level clipped to the top
        send_word(pixel_word(8'd0));
        send_word(pixel_word(8'd1));
        send_word(pixel_word(8'd2));
        send_word(gray_word(8'd5, 8'd179));    // must not disturb the byte being built
        send_word(pixel_word(8'd255));
        // leave a partial byte; the next mode write has to drop it
        send_word(pixel_word(8'd3));
        send_word(pixel_word(8'd4));
        wait_for_bytes();
    endtask

    task automatic test_dither_traffic();
        run_random_phase(MODE_DITHER, 300, 6, 6);
        run_random_phase(MODE_DITHER, 150, 0, 0);   // full rate, no gaps at all
    endtask

    task automatic test_mono_traffic();
        run_random_phase(MODE_MONO, 300, 6, 6);
        run_random_phase(MODE_MONO, 150, 6, 0);
    endtask

    // output held off for a long stretch while pixels keep coming, so the block
    // fills and pushes back on its input
    task automatic test_output_backpressure();
        item_word_t w;
        set_mode(MODE_DITHER);
        send_gap_max       = 0;
        recv_gap_max       = 6;
        ready_hold_request = HOLD_CYCLES;
        repeat (120)
        begin
            w           = random_word();
            w.operation = OP_PIXEL;
            send_word(w);
        end
        wait_for_bytes();
        run_random_phase(MODE_DITHER, 180, 0, 6);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;

        // model state after reset
        for (int i = 0; i < TABLE_ENTRIES; i++)
            palette_model[i] = 5'h00;
        palette_model[0] = 5'h10;
        top_acc    = 8'h00;
        bottom_acc = 8'h00;
        pack_phase = 3'd0;
        mono_model = MODE_DITHER;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unwritten_entries();
        test_palette_levels();
        test_dither_traffic();
        test_mono_traffic();
        test_output_backpressure();

        if (expected_bytes.size() != 0)
            flag_error($sformatf("%0d predicted words never came out", expected_bytes.size()));

        $display("covered %0d palette writes and %0d pixels in both packing modes",
                 palette_writes, pixels_sent);
        $display("checked %0d packed words across %0d mode writes, %0d failures",
                 words_checked, mode_writes, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ipmdp_pkg.sv
src/indexed_pixel_mono_dither_packer.sv
bench/tb_indexed_pixel_mono_dither_packer.sv
